/* design/bitmap_page_frame_allocator_defines.svh */
// Assertion shorthands for the page frame allocator.
// Every check samples on clk and is off while rst_n is low.
`ifndef BITMAP_PAGE_FRAME_ALLOCATOR_DEFINES_SVH
`define BITMAP_PAGE_FRAME_ALLOCATOR_DEFINES_SVH

// Condition must hold in the same cycle.
`define BPFA_AST_NOW(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Consequent must hold in the same cycle as the antecedent.
`define BPFA_AST_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define BPFA_AST_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* design/bpfa_pkg.sv */
`timescale 1ns / 1ps

package bpfa_pkg;

  localparam int POOL_PAGES    = 4096;
  localparam int MAP_WORD_BITS = 32;
  localparam int PAGE_BYTES    = 4096;

  localparam int ADDR_W   = 48;
  localparam int INDEX_W  = 12;
  localparam int REQ_W    = 2;

  localparam int MAP_WORDS  = (POOL_PAGES + MAP_WORD_BITS - 1) / MAP_WORD_BITS;
  localparam int BIT_W      = $clog2(MAP_WORD_BITS);
  localparam int WORD_IDX_W = $clog2(MAP_WORDS);
  localparam int PAGE_IDX_W = $clog2(POOL_PAGES);
  localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);
  localparam int PN_W       = ADDR_W - PAGE_SHIFT;

  // Summary bits (one per map word) are scanned one map-word-wide group at a time.
  localparam int NUM_GROUPS = (MAP_WORDS + MAP_WORD_BITS - 1) / MAP_WORD_BITS;
  localparam int GRP_W      = (NUM_GROUPS > 1) ? $clog2(NUM_GROUPS) : 1;
  localparam int SUMM_W     = NUM_GROUPS * MAP_WORD_BITS;

  typedef logic [MAP_WORD_BITS-1:0] map_word_t;

  localparam map_word_t WORD_ONES = '1;
  localparam map_word_t WORD_ONE  = map_word_t'(1);

  localparam logic [REQ_W-1:0] REQ_ALLOC = 2'd0;
  localparam logic [REQ_W-1:0] REQ_FREE  = 2'd1;
  localparam logic [REQ_W-1:0] REQ_RANGE = 2'd2;

  typedef enum logic [1:0] {
    ST_DONE    = 2'd0,
    ST_EMPTY   = 2'd1,
    ST_OUTSIDE = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CALC_E,
    S_CALC_S,
    S_CHECK,
    S_SCAN,
    S_PICK,
    S_RD,
    S_MOD,
    S_RESP
  } state_t;

  typedef struct packed {
    logic                  rd;
    logic                  wr;
    logic [WORD_IDX_W-1:0] addr;
    map_word_t             wdata;
  } map_req_t;

endpackage

/* design/bpfa_ffs.sv */
`timescale 1ns / 1ps

// Find the lowest set bit of one map word.
module bpfa_ffs (
  input  bpfa_pkg::map_word_t      vec,
  output logic                     found,
  output logic [bpfa_pkg::BIT_W-1:0] idx
);

  bpfa_pkg::map_word_t low;

  always_comb begin
    // isolate the lowest set bit, then encode the one-hot position
    low = vec & (~vec + bpfa_pkg::WORD_ONE);
    idx = '0;
    for (int i = 0; i < bpfa_pkg::MAP_WORD_BITS; i++) begin
      for (int b = 0; b < bpfa_pkg::BIT_W; b++) begin
        if (((i >> b) & 1) != 0) begin
          idx[b] = idx[b] | low[i];
        end
      end
    end
  end

  assign found = |vec;

endmodule

/* design/bpfa_map.sv */
`timescale 1ns / 1ps

// Free-page bitmap: one read or write port, registered read data.
// Words never written read as zero (every page used); a summary bit per
// word tells whether that word holds any free page.
module bpfa_map (
  input  logic                               clk,
  input  logic                               rst_n,
  input  bpfa_pkg::map_req_t                 map_req,
  output bpfa_pkg::map_word_t                rdata,
  output logic [bpfa_pkg::MAP_WORDS-1:0]     summary
);

  bpfa_pkg::map_word_t                mem_r [bpfa_pkg::MAP_WORDS];
  bpfa_pkg::map_word_t                mem_q_r;
  logic [bpfa_pkg::MAP_WORDS-1:0]     vld_r;
  logic [bpfa_pkg::MAP_WORDS-1:0]     summ_r;
  logic                               vld_q_r;

  always_ff @(posedge clk) begin
    if (map_req.wr) begin
      mem_r[map_req.addr] <= map_req.wdata;
    end
    if (map_req.rd) begin
      mem_q_r <= mem_r[map_req.addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r   <= '0;
      summ_r  <= '0;
      vld_q_r <= 1'b0;
    end else begin
      if (map_req.wr) begin
        vld_r[map_req.addr]  <= 1'b1;
        summ_r[map_req.addr] <= |map_req.wdata;
      end
      if (map_req.rd) begin
        vld_q_r <= vld_r[map_req.addr];
      end
    end
  end

  assign rdata   = vld_q_r ? mem_q_r : '0;
  assign summary = summ_r;

endmodule

/* design/bitmap_page_frame_allocator.sv */
`timescale 1ns / 1ps
// Throughput: one request at a time; the single-port bitmap and the one find-first unit set it.
// A result waits in the output register while the next request is taken.
// Reset (rst_n low, synchronous): all pages used, base address 0, no clearing pass needed.
`include "bitmap_page_frame_allocator_defines.svh"

module bitmap_page_frame_allocator (
  input  logic                                clk,
  input  logic                                rst_n,

  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [bpfa_pkg::REQ_W-1:0]          in_req_type,
  input  logic [bpfa_pkg::ADDR_W-1:0]         in_start_addr,
  input  logic [bpfa_pkg::ADDR_W-1:0]         in_end_addr,
  input  logic                                in_mark_free,

  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [bpfa_pkg::ADDR_W-1:0]         out_page_addr,
  output logic [bpfa_pkg::INDEX_W-1:0]        out_frame_idx,
  output logic [1:0]                          out_status,

  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [bpfa_pkg::ADDR_W-1:0]         cfg_base_address
);

  // ---------------------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------------------
  bpfa_pkg::state_t                     state_r, state_nxt;
  logic [bpfa_pkg::ADDR_W-1:0]          base_r;

  // latched request
  logic [bpfa_pkg::REQ_W-1:0]           req_r, req_nxt;
  logic [bpfa_pkg::ADDR_W-1:0]          start_r, start_nxt;
  logic [bpfa_pkg::ADDR_W-1:0]          end_r, end_nxt;
  logic                                 mfree_r, mfree_nxt;
  bpfa_pkg::status_t                    status_r, status_nxt;

  // page range in page numbers, then in word / bit coordinates
  logic [bpfa_pkg::PN_W-1:0]            s_pn_r, s_pn_nxt;
  logic [bpfa_pkg::PN_W-1:0]            e_pn_r, e_pn_nxt;
  logic [bpfa_pkg::WORD_IDX_W-1:0]      cur_w_r, cur_w_nxt;
  logic [bpfa_pkg::WORD_IDX_W-1:0]      s_w_r, s_w_nxt;
  logic [bpfa_pkg::WORD_IDX_W-1:0]      last_w_r, last_w_nxt;
  logic [bpfa_pkg::BIT_W-1:0]           s_bit_r, s_bit_nxt;
  logic [bpfa_pkg::BIT_W-1:0]           e_bit_r, e_bit_nxt;

  // allocate scan
  logic [bpfa_pkg::GRP_W-1:0]           grp_r, grp_nxt;
  logic [bpfa_pkg::WORD_IDX_W-1:0]      word_r, word_nxt;
  logic [bpfa_pkg::PAGE_IDX_W-1:0]      page_r, page_nxt;

  // output register
  logic                                 out_valid_r, out_valid_nxt;
  logic [bpfa_pkg::ADDR_W-1:0]          out_page_addr_r, out_page_addr_nxt;
  logic [bpfa_pkg::INDEX_W-1:0]         out_frame_idx_r, out_frame_idx_nxt;
  bpfa_pkg::status_t                    out_status_r, out_status_nxt;

  // ---------------------------------------------------------------------------
  // Handshakes
  // ---------------------------------------------------------------------------
  logic in_acc;
  logic out_free;

  // Take a new request only when the sequencer is idle; the output register
  // decouples us from the consumer, so a pending result does not block.
  assign in_stall  = (state_r != bpfa_pkg::S_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign cfg_ready = (state_r == bpfa_pkg::S_IDLE);
  // output slot can take a new beat this cycle
  assign out_free  = !out_valid_r || !out_stall;

  // ---------------------------------------------------------------------------
  // Shared datapath
  // ---------------------------------------------------------------------------
  // One 49-bit subtractor against the base address. CALC_E uses it on the
  // range end, CALC_S on the start address (free or range).
  logic [bpfa_pkg::ADDR_W-1:0]  sub_a;
  logic [bpfa_pkg::ADDR_W:0]    diff;
  logic                         borrow;
  logic [bpfa_pkg::PN_W-1:0]    diff_pn;

  assign sub_a   = (state_r == bpfa_pkg::S_CALC_E) ? end_r : start_r;
  assign diff    = {1'b0, sub_a} - {1'b0, base_r};
  assign borrow  = diff[bpfa_pkg::ADDR_W];
  assign diff_pn = diff[bpfa_pkg::ADDR_W-1:bpfa_pkg::PAGE_SHIFT];

  // Range checks on the latched page numbers.
  logic                         s_gt_e;
  logic                         s_past;
  logic [bpfa_pkg::PN_W-1:0]    e_clip;

  assign s_gt_e = (s_pn_r > e_pn_r);
  assign s_past = (s_pn_r >= bpfa_pkg::PN_W'(bpfa_pkg::POOL_PAGES));
  // clip pages beyond the pool to the last page
  assign e_clip = (e_pn_r >= bpfa_pkg::PN_W'(bpfa_pkg::POOL_PAGES)) ?
                  bpfa_pkg::PN_W'(bpfa_pkg::POOL_PAGES - 1) : e_pn_r;

  // Bitmap and its summary bits.
  bpfa_pkg::map_req_t               map_req;
  bpfa_pkg::map_word_t              map_rdata;
  logic [bpfa_pkg::MAP_WORDS-1:0]   summary;
  logic [bpfa_pkg::SUMM_W-1:0]      summ_pad;

  bpfa_map u_map (
    .clk     (clk),
    .rst_n   (rst_n),
    .map_req (map_req),
    .rdata   (map_rdata),
    .summary (summary)
  );

  assign summ_pad = bpfa_pkg::SUMM_W'(summary);

  // The one find-first unit: in SCAN it looks at a group of summary bits to
  // pick the first word with a free page; in PICK at that word's data to
  // pick the page itself.
  bpfa_pkg::map_word_t              ffs_in;
  logic                             ffs_found;
  logic [bpfa_pkg::BIT_W-1:0]       ffs_idx;
  logic [bpfa_pkg::WORD_IDX_W-1:0]  word_sel;

  assign ffs_in = (state_r == bpfa_pkg::S_PICK) ? map_rdata :
                  summ_pad[grp_r * bpfa_pkg::MAP_WORD_BITS +: bpfa_pkg::MAP_WORD_BITS];

  bpfa_ffs u_ffs (
    .vec   (ffs_in),
    .found (ffs_found),
    .idx   (ffs_idx)
  );

  assign word_sel = bpfa_pkg::WORD_IDX_W'({grp_r, ffs_idx});

  // Bit mask of the pages inside the range for the current word: the first
  // word starts at the start bit, the last word ends at the end bit.
  logic [bpfa_pkg::BIT_W-1:0]   lo_bit;
  logic [bpfa_pkg::BIT_W-1:0]   hi_bit;
  bpfa_pkg::map_word_t          range_mask;

  assign lo_bit     = (cur_w_r == s_w_r)    ? s_bit_r : '0;
  assign hi_bit     = (cur_w_r == last_w_r) ? e_bit_r : '1;
  assign range_mask = (bpfa_pkg::WORD_ONES << lo_bit) &
                      (bpfa_pkg::WORD_ONES >>
                       (bpfa_pkg::BIT_W'(bpfa_pkg::MAP_WORD_BITS - 1) - hi_bit));

  logic alloc_ok;
  assign alloc_ok = (req_r == bpfa_pkg::REQ_ALLOC) && (status_r == bpfa_pkg::ST_DONE);

  // ---------------------------------------------------------------------------
  // Sequencer: next state
  // ---------------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      bpfa_pkg::S_IDLE: begin
        if (in_acc) begin
          unique case (in_req_type)
            bpfa_pkg::REQ_ALLOC: state_nxt = bpfa_pkg::S_SCAN;
            bpfa_pkg::REQ_FREE:  state_nxt = bpfa_pkg::S_CALC_S;
            bpfa_pkg::REQ_RANGE: state_nxt = bpfa_pkg::S_CALC_E;
            default:             state_nxt = bpfa_pkg::S_RESP;
          endcase
        end
      end
      bpfa_pkg::S_CALC_E: begin
        state_nxt = borrow ? bpfa_pkg::S_RESP : bpfa_pkg::S_CALC_S;
      end
      bpfa_pkg::S_CALC_S: begin
        state_nxt = (borrow && (req_r == bpfa_pkg::REQ_FREE)) ?
                    bpfa_pkg::S_RESP : bpfa_pkg::S_CHECK;
      end
      bpfa_pkg::S_CHECK: begin
        state_nxt = (s_gt_e || s_past) ? bpfa_pkg::S_RESP : bpfa_pkg::S_RD;
      end
      bpfa_pkg::S_SCAN: begin
        if (ffs_found) begin
          state_nxt = bpfa_pkg::S_PICK;
        end else if (grp_r == bpfa_pkg::GRP_W'(bpfa_pkg::NUM_GROUPS - 1)) begin
          state_nxt = bpfa_pkg::S_RESP;
        end
      end
      bpfa_pkg::S_PICK: state_nxt = bpfa_pkg::S_RESP;
      bpfa_pkg::S_RD:   state_nxt = bpfa_pkg::S_MOD;
      bpfa_pkg::S_MOD: begin
        state_nxt = (cur_w_r == last_w_r) ? bpfa_pkg::S_RESP : bpfa_pkg::S_RD;
      end
      bpfa_pkg::S_RESP: begin
        if (out_free) begin
          state_nxt = bpfa_pkg::S_IDLE;
        end
      end
      default: state_nxt = bpfa_pkg::S_IDLE;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Sequencer: datapath controls and register updates
  // ---------------------------------------------------------------------------
  always_comb begin
    req_nxt            = req_r;
    start_nxt          = start_r;
    end_nxt            = end_r;
    mfree_nxt          = mfree_r;
    status_nxt         = status_r;
    s_pn_nxt           = s_pn_r;
    e_pn_nxt           = e_pn_r;
    cur_w_nxt          = cur_w_r;
    s_w_nxt            = s_w_r;
    last_w_nxt         = last_w_r;
    s_bit_nxt          = s_bit_r;
    e_bit_nxt          = e_bit_r;
    grp_nxt            = grp_r;
    word_nxt           = word_r;
    page_nxt           = page_r;
    out_page_addr_nxt  = out_page_addr_r;
    out_frame_idx_nxt  = out_frame_idx_r;
    out_status_nxt     = out_status_r;
    map_req            = '0;

    // drop the output beat once taken; a new load below overrides
    out_valid_nxt = out_valid_r && out_stall;

    unique case (state_r)
      bpfa_pkg::S_IDLE: begin
        if (in_acc) begin
          req_nxt   = in_req_type;
          start_nxt = in_start_addr;
          end_nxt   = in_end_addr;
          // a single-page free is a one-page range marked free
          mfree_nxt = (in_req_type == bpfa_pkg::REQ_FREE) || in_mark_free;
          grp_nxt   = '0;
          case (in_req_type) inside
            bpfa_pkg::REQ_ALLOC,
            bpfa_pkg::REQ_FREE,
            bpfa_pkg::REQ_RANGE: status_nxt = bpfa_pkg::ST_DONE;
            default:             status_nxt = bpfa_pkg::ST_OUTSIDE;
          endcase
        end
      end
      bpfa_pkg::S_CALC_E: begin
        // range end below the base: ignore the whole request
        if (borrow) begin
          status_nxt = bpfa_pkg::ST_OUTSIDE;
        end else begin
          e_pn_nxt = diff_pn;
        end
      end
      bpfa_pkg::S_CALC_S: begin
        if (borrow) begin
          // free below base is ignored; range start is raised to the base
          if (req_r == bpfa_pkg::REQ_FREE) begin
            status_nxt = bpfa_pkg::ST_OUTSIDE;
          end else begin
            s_pn_nxt = '0;
          end
        end else begin
          s_pn_nxt = diff_pn;
          if (req_r == bpfa_pkg::REQ_FREE) begin
            e_pn_nxt = diff_pn;
          end
        end
      end
      bpfa_pkg::S_CHECK: begin
        // empty range answers done; a start past the pool answers outside
        if (!s_gt_e && s_past) begin
          status_nxt = bpfa_pkg::ST_OUTSIDE;
        end else if (!s_gt_e) begin
          s_w_nxt    = s_pn_r[bpfa_pkg::PAGE_IDX_W-1:bpfa_pkg::BIT_W];
          cur_w_nxt  = s_pn_r[bpfa_pkg::PAGE_IDX_W-1:bpfa_pkg::BIT_W];
          s_bit_nxt  = s_pn_r[bpfa_pkg::BIT_W-1:0];
          last_w_nxt = e_clip[bpfa_pkg::PAGE_IDX_W-1:bpfa_pkg::BIT_W];
          e_bit_nxt  = e_clip[bpfa_pkg::BIT_W-1:0];
        end
      end
      bpfa_pkg::S_SCAN: begin
        // first summary group with a free word: read that word
        if (ffs_found) begin
          map_req.rd   = 1'b1;
          map_req.addr = word_sel;
          word_nxt     = word_sel;
        end else if (grp_r == bpfa_pkg::GRP_W'(bpfa_pkg::NUM_GROUPS - 1)) begin
          status_nxt = bpfa_pkg::ST_EMPTY;
        end else begin
          grp_nxt = grp_r + 1'b1;
        end
      end
      bpfa_pkg::S_PICK: begin
        // claim the lowest free page of the word
        map_req.wr    = 1'b1;
        map_req.addr  = word_r;
        map_req.wdata = map_rdata & ~(bpfa_pkg::WORD_ONE << ffs_idx);
        page_nxt      = bpfa_pkg::PAGE_IDX_W'({word_r, ffs_idx});
        status_nxt    = bpfa_pkg::ST_DONE;
      end
      bpfa_pkg::S_RD: begin
        map_req.rd   = 1'b1;
        map_req.addr = cur_w_r;
      end
      bpfa_pkg::S_MOD: begin
        // read-modify-write of one word, then advance
        map_req.wr    = 1'b1;
        map_req.addr  = cur_w_r;
        map_req.wdata = mfree_r ? (map_rdata | range_mask) : (map_rdata & ~range_mask);
        if (cur_w_r != last_w_r) begin
          cur_w_nxt = cur_w_r + 1'b1;
        end
      end
      bpfa_pkg::S_RESP: begin
        // hold here until the output register is free, then load the beat
        if (out_free) begin
          out_valid_nxt      = 1'b1;
          out_status_nxt     = status_r;
          out_page_addr_nxt  = alloc_ok ?
              base_r + (bpfa_pkg::ADDR_W'(page_r) << bpfa_pkg::PAGE_SHIFT) : '0;
          out_frame_idx_nxt  = alloc_ok ? bpfa_pkg::INDEX_W'(page_r) : '0;
        end
      end
      default: begin
      end
    endcase
  end

  // ---------------------------------------------------------------------------
  // Flops
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= bpfa_pkg::S_IDLE;
      base_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        base_r <= cfg_base_address;
      end
    end
  end

  always_ff @(posedge clk) begin
    req_r            <= req_nxt;
    start_r          <= start_nxt;
    end_r            <= end_nxt;
    mfree_r          <= mfree_nxt;
    status_r         <= status_nxt;
    s_pn_r           <= s_pn_nxt;
    e_pn_r           <= e_pn_nxt;
    cur_w_r          <= cur_w_nxt;
    s_w_r            <= s_w_nxt;
    last_w_r         <= last_w_nxt;
    s_bit_r          <= s_bit_nxt;
    e_bit_r          <= e_bit_nxt;
    grp_r            <= grp_nxt;
    word_r           <= word_nxt;
    page_r           <= page_nxt;
    out_page_addr_r  <= out_page_addr_nxt;
    out_frame_idx_r  <= out_frame_idx_nxt;
    out_status_r     <= out_status_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_page_addr  = out_page_addr_r;
  assign out_frame_idx  = out_frame_idx_r;
  assign out_status     = out_status_r;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  logic out_not_alloc;
  logic out_fields_zero;
  logic walk_in_span;

  assign out_not_alloc   = out_valid && (out_status != 2'(bpfa_pkg::ST_DONE));
  assign out_fields_zero = (out_page_addr == '0) && (out_frame_idx == '0);
  assign walk_in_span    = (cur_w_r >= s_w_r) && (cur_w_r <= last_w_r);

  `BPFA_AST_NXT(a_busy_after_accept, in_acc, in_stall, "accept did not start the sequencer")
  `BPFA_AST_NOW(a_map_one_port, !(map_req.rd && map_req.wr), "bitmap read and write together")
  `BPFA_AST_IMP(a_fields_zero, out_not_alloc, out_fields_zero, "page data on non-allocate beat")
  `BPFA_AST_IMP(a_word_in_range, state_r == bpfa_pkg::S_MOD, walk_in_span, "walk left word span")

endmodule
